FILE: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define VRCG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrcg assertion failed");

// Next-cycle implication, masked during reset.
`define VRCG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrcg assertion failed");

// Next-cycle implication that also holds across reset.
`define VRCG_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vrcg assertion failed");

`endif

FILE: design/vrcg_pkg.sv
`default_nettype none
package vrcg_pkg;
   localparam int GRID_XY_DEF = 64;
   localparam int GRID_Z_DEF  = 16;

   localparam int OPC_W   = 3;
   localparam int VXY_W   = 8;
   localparam int VZ_W    = 6;
   localparam int HXY_W   = 6;
   localparam int HZ_W    = 4;
   localparam int CXY_W   = 6;
   localparam int CZ_W    = 4;
   localparam int CELL_W  = 3;
   localparam int COORD_W = 10;  // signed working coordinate
   localparam int AXIS_W  = 8;   // ray extents, up to 191

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 2'd2;

   localparam logic [CXY_W-1:0] CENTER_X_RST = 6'd32;
   localparam logic [CXY_W-1:0] CENTER_Y_RST = 6'd32;
   localparam logic [CZ_W-1:0]  CENTER_Z_RST = 4'd8;

   localparam logic [OPC_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OPC_W-1:0] OP_SCAN  = 3'd1;
   localparam logic [OPC_W-1:0] OP_OBS   = 3'd2;
   localparam logic [OPC_W-1:0] OP_RAY   = 3'd3;
   localparam logic [OPC_W-1:0] OP_QUERY = 3'd4;

   localparam logic [CELL_W-1:0] CELL_SCAN = 3'd1;
   localparam logic [CELL_W-1:0] CELL_OBS  = 3'd2;
   localparam logic [CELL_W-1:0] CELL_RAY  = 3'd4;
endpackage
`default_nettype wire

FILE: design/vrcg_if.sv
`default_nettype none
interface vrcg_req_if;
   logic                                valid;
   logic                                ready;
   logic [vrcg_pkg::OPC_W-1:0]          opcode;
   logic signed [vrcg_pkg::VXY_W-1:0]   voxel_x;
   logic signed [vrcg_pkg::VXY_W-1:0]   voxel_y;
   logic signed [vrcg_pkg::VZ_W-1:0]    voxel_z;
   logic [vrcg_pkg::HXY_W-1:0]          half_xy;
   logic [vrcg_pkg::HZ_W-1:0]           half_z;
   modport source (output valid, opcode, voxel_x, voxel_y, voxel_z, half_xy, half_z,
                   input ready);
   modport sink (input valid, opcode, voxel_x, voxel_y, voxel_z, half_xy, half_z,
                 output ready);
endinterface

interface vrcg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vrcg_pkg::CELL_W-1:0] cell_bits;
   logic                        in_grid;
   logic                        dynamic_hit;
   modport source (output valid, cell_bits, in_grid, dynamic_hit, input ready);
   modport sink (input valid, cell_bits, in_grid, dynamic_hit, output ready);
endinterface

interface vrcg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vrcg_pkg::CSR_IDX_W-1:0]  addr;
   logic [vrcg_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: design/voxel_ray_clearing_grid.sv
// Sequence, accept to rsp valid: in grid an obstacle reads then writes its cell and a
//   query reads it; outside, both go straight to done. A scan box reads and writes each
//   in-grid cell; a ray advances, reads and marks each cell before its end, stopping at
//   a scan cell or the grid edge. One item at a time, set by the single read-modify-write
//   loop on the cell RAM. Reset: synchronous; clears every cell with req_chan.ready low;
//   centre registers return to 32/32/8.
`default_nettype none
module voxel_ray_clearing_grid #(
   parameter int GRID_XY = vrcg_pkg::GRID_XY_DEF,
   parameter int GRID_Z  = vrcg_pkg::GRID_Z_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   vrcg_req_if.sink     req_chan,
   vrcg_rsp_if.source   rsp_chan,
   vrcg_csr_if.sink     csr_chan
);
   localparam int XW = $clog2(GRID_XY);
   localparam int ZW = $clog2(GRID_Z);
   localparam int AW = 2 * XW + ZW;
   localparam int CW = vrcg_pkg::COORD_W;
   localparam int MW = vrcg_pkg::AXIS_W;
   localparam int LW = vrcg_pkg::CELL_W;

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLR    = 4'd1;
   localparam logic [3:0] ST_BOX_RD = 4'd2;
   localparam logic [3:0] ST_BOX_WR = 4'd3;
   localparam logic [3:0] ST_RAY_AD = 4'd4;
   localparam logic [3:0] ST_RAY_RD = 4'd5;
   localparam logic [3:0] ST_RAY_WR = 4'd6;
   localparam logic [3:0] ST_PT_RD  = 4'd7;
   localparam logic [3:0] ST_PT_WR  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam logic signed [CW-1:0] GXY_LAST = CW'(GRID_XY - 1);
   localparam logic signed [CW-1:0] GZ_LAST  = CW'(GRID_Z - 1);

   // ---------------- configuration ----------------
   logic [vrcg_pkg::CXY_W-1:0] center_x_ff, center_y_ff;
   logic [vrcg_pkg::CZ_W-1:0]  center_z_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= vrcg_pkg::CENTER_X_RST;
         center_y_ff <= vrcg_pkg::CENTER_Y_RST;
         center_z_ff <= vrcg_pkg::CENTER_Z_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            vrcg_pkg::CSR_CENTER_X: center_x_ff <= csr_chan.data;
            vrcg_pkg::CSR_CENTER_Y: center_y_ff <= csr_chan.data;
            vrcg_pkg::CSR_CENTER_Z: center_z_ff <= csr_chan.data[vrcg_pkg::CZ_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- registers ----------------
   logic [3:0]             state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [vrcg_pkg::OPC_W-1:0] op_ff, op_in;
   logic signed [CW-1:0]   px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [CW-1:0]   x0_ff, x1_ff, y0_ff, y1_ff, z0_ff, z1_ff;
   logic signed [CW-1:0]   x0_in, x1_in, y0_in, y1_in, z0_in, z1_in;
   logic [MW-1:0]          ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic [MW-1:0]          rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic                   nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [MW-1:0]          major_ff, major_in;
   logic [MW-1:0]          step_ff, step_in;
   logic [1:0]             axis_ff, axis_in;
   logic [LW-1:0]          bits_ff, bits_in;
   logic                   ing_ff, ing_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]          rsp_bits_ff, rsp_bits_in;
   logic                   rsp_ing_ff, rsp_ing_in;

   // ---------------- cell memory ----------------
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [LW-1:0] mem_wdata, mem_rdata;

   vrcg_ram #(.WIDTH(LW), .DEPTH(1 << AW)) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // cell address is the packed {z, y, x}
   logic [AW-1:0] cur_addr;
   assign cur_addr = {pz_ff[ZW-1:0], py_ff[XW-1:0], px_ff[XW-1:0]};

   logic cur_inside;
   assign cur_inside = (px_ff >= 0) && (px_ff <= GXY_LAST) && (py_ff >= 0) &&
                       (py_ff <= GXY_LAST) && (pz_ff >= 0) && (pz_ff <= GZ_LAST);

   // ---------------- item decode at accept ----------------
   logic signed [CW-1:0] tx, ty, tz, hxy, hz, ox, oy, oz, dx, dy, dz;
   logic signed [CW-1:0] lx, hx, ly, hy, lz, hzz;
   logic signed [CW-1:0] bx0, bx1, by0, by1, bz0, bz1;
   logic                 t_inside, box_empty;
   logic [MW-1:0]        adx, ady, adz;
   logic                 req_fire;

   always_comb begin
      tx  = CW'(req_chan.voxel_x);
      ty  = CW'(req_chan.voxel_y);
      tz  = CW'(req_chan.voxel_z);
      hxy = $signed({{(CW - vrcg_pkg::HXY_W){1'b0}}, req_chan.half_xy});
      hz  = $signed({{(CW - vrcg_pkg::HZ_W){1'b0}}, req_chan.half_z});
      ox  = $signed({{(CW - vrcg_pkg::CXY_W){1'b0}}, center_x_ff});
      oy  = $signed({{(CW - vrcg_pkg::CXY_W){1'b0}}, center_y_ff});
      oz  = $signed({{(CW - vrcg_pkg::CZ_W){1'b0}}, center_z_ff});
      dx  = tx - ox;
      dy  = ty - oy;
      dz  = tz - oz;
      adx = dx[CW-1] ? MW'(-dx) : MW'(dx);
      ady = dy[CW-1] ? MW'(-dy) : MW'(dy);
      adz = dz[CW-1] ? MW'(-dz) : MW'(dz);
      t_inside = (tx >= 0) && (tx <= GXY_LAST) && (ty >= 0) && (ty <= GXY_LAST) &&
                 (tz >= 0) && (tz <= GZ_LAST);
      // box bounds clamped to the grid
      lx  = tx - hxy;  hx  = tx + hxy;
      ly  = ty - hxy;  hy  = ty + hxy;
      lz  = tz - hz;   hzz = tz + hz;
      bx0 = (lx < 0) ? '0 : lx;   bx1 = (hx > GXY_LAST) ? GXY_LAST : hx;
      by0 = (ly < 0) ? '0 : ly;   by1 = (hy > GXY_LAST) ? GXY_LAST : hy;
      bz0 = (lz < 0) ? '0 : lz;   bz1 = (hzz > GZ_LAST) ? GZ_LAST : hzz;
      box_empty = (bx0 > bx1) || (by0 > by1) || (bz0 > bz1);
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   // ---------------- ray advance: exact floor(i*minor/major) by remainders ----------------
   logic signed [CW-1:0] adv_px, adv_py, adv_pz;
   logic [MW-1:0]        adv_rx, adv_ry, adv_rz;
   logic [MW:0]          sum_x, sum_y, sum_z;
   logic                 mv_x, mv_y, mv_z;

   always_comb begin
      sum_x = {1'b0, rx_ff} + {1'b0, ax_ff};
      sum_y = {1'b0, ry_ff} + {1'b0, ay_ff};
      sum_z = {1'b0, rz_ff} + {1'b0, az_ff};
      mv_x  = (axis_ff == AX_X) || (sum_x >= {1'b0, major_ff});
      mv_y  = (axis_ff == AX_Y) || (sum_y >= {1'b0, major_ff});
      mv_z  = (axis_ff == AX_Z) || (sum_z >= {1'b0, major_ff});
      adv_rx = (sum_x >= {1'b0, major_ff}) ? MW'(sum_x - {1'b0, major_ff}) : MW'(sum_x);
      adv_ry = (sum_y >= {1'b0, major_ff}) ? MW'(sum_y - {1'b0, major_ff}) : MW'(sum_y);
      adv_rz = (sum_z >= {1'b0, major_ff}) ? MW'(sum_z - {1'b0, major_ff}) : MW'(sum_z);
      adv_px = !mv_x ? px_ff : (nx_ff ? px_ff - CW'(1) : px_ff + CW'(1));
      adv_py = !mv_y ? py_ff : (ny_ff ? py_ff - CW'(1) : py_ff + CW'(1));
      adv_pz = !mv_z ? pz_ff : (nz_ff ? pz_ff - CW'(1) : pz_ff + CW'(1));
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      op_in      = op_ff;
      px_in = px_ff;  py_in = py_ff;  pz_in = pz_ff;
      x0_in = x0_ff;  x1_in = x1_ff;  y0_in = y0_ff;
      y1_in = y1_ff;  z0_in = z0_ff;  z1_in = z1_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  az_in = az_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rz_in = rz_ff;
      nx_in = nx_ff;  ny_in = ny_ff;  nz_in = nz_ff;
      major_in = major_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      bits_in  = bits_ff;
      ing_in   = ing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_ing_in   = rsp_ing_ff;
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = mem_rdata;
      mem_raddr = cur_addr;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_chan.opcode;
               ing_in  = t_inside;
               bits_in = '0;
               case (req_chan.opcode)
                  vrcg_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  vrcg_pkg::OP_SCAN: begin
                     x0_in = bx0;  x1_in = bx1;  y0_in = by0;
                     y1_in = by1;  z0_in = bz0;  z1_in = bz1;
                     px_in = bx0;  py_in = by0;  pz_in = bz0;
                     state_in = box_empty ? ST_DONE : ST_BOX_RD;
                  end
                  vrcg_pkg::OP_OBS, vrcg_pkg::OP_QUERY: begin
                     px_in = tx;  py_in = ty;  pz_in = tz;
                     state_in = t_inside ? ST_PT_RD : ST_DONE;
                  end
                  vrcg_pkg::OP_RAY: begin
                     px_in = ox;  py_in = oy;  pz_in = oz;
                     ax_in = adx; ay_in = ady; az_in = adz;
                     nx_in = dx[CW-1];  ny_in = dy[CW-1];  nz_in = dz[CW-1];
                     rx_in = '0;  ry_in = '0;  rz_in = '0;
                     step_in = '0;
                     // dominant axis, ties to x then y
                     if (adx >= ady && adx >= adz) begin
                        axis_in = AX_X;  major_in = adx;
                     end else if (ady >= adz) begin
                        axis_in = AX_Y;  major_in = ady;
                     end else begin
                        axis_in = AX_Z;  major_in = adz;
                     end
                     state_in = ST_RAY_AD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (&clr_cnt_ff) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_BOX_RD: state_in = ST_BOX_WR;
         ST_BOX_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | vrcg_pkg::CELL_SCAN;
            state_in  = ST_BOX_RD;
            if (px_ff == x1_ff) begin
               px_in = x0_ff;
               if (py_ff == y1_ff) begin
                  py_in = y0_ff;
                  if (pz_ff == z1_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     pz_in = pz_ff + CW'(1);
                  end
               end else begin
                  py_in = py_ff + CW'(1);
               end
            end else begin
               px_in = px_ff + CW'(1);
            end
         end
         ST_RAY_AD: begin
            px_in = adv_px;  py_in = adv_py;  pz_in = adv_pz;
            rx_in = adv_rx;  ry_in = adv_ry;  rz_in = adv_rz;
            step_in  = step_ff + MW'(1);
            state_in = ST_RAY_RD;
         end
         ST_RAY_RD: begin
            // end cell is never marked; leaving the grid stops the walk
            state_in = (step_ff >= major_ff || !cur_inside) ? ST_DONE : ST_RAY_WR;
         end
         ST_RAY_WR: begin
            if (mem_rdata[0]) begin
               state_in = ST_DONE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata | vrcg_pkg::CELL_RAY;
               state_in  = ST_RAY_AD;
            end
         end
         ST_PT_RD: state_in = ST_PT_WR;
         ST_PT_WR: begin
            if (op_ff == vrcg_pkg::OP_OBS) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata | vrcg_pkg::CELL_OBS;
            end else begin
               bits_in = mem_rdata;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register frees as soon as the previous result is taken
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = bits_ff;
               rsp_ing_in   = ing_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
      x0_ff <= x0_in;  x1_ff <= x1_in;  y0_ff <= y0_in;
      y1_ff <= y1_in;  z0_ff <= z0_in;  z1_ff <= z1_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  az_ff <= az_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;  rz_ff <= rz_in;
      nx_ff <= nx_in;  ny_ff <= ny_in;  nz_ff <= nz_in;
      major_ff    <= major_in;
      step_ff     <= step_in;
      axis_ff     <= axis_in;
      bits_ff     <= bits_in;
      ing_ff      <= ing_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_ing_ff  <= rsp_ing_in;
   end

   // bits are only nonzero for an in-grid query, so the ray flag is the hit
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cell_bits   = rsp_bits_ff;
   assign rsp_chan.in_grid     = rsp_ing_ff;
   assign rsp_chan.dynamic_hit = rsp_bits_ff[2];
endmodule
`default_nettype wire

FILE: design/vrcg_ram.sv
`default_nettype none
module vrcg_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/vrcg_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vrcg_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [vrcg_pkg::CELL_W-1:0] cell_bits,
   input wire logic                        in_grid,
   input wire logic                        dynamic_hit
);
   `VRCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(cell_bits) && $stable(in_grid) && $stable(dynamic_hit))
   `VRCG_ASSERT_NEXT_NR(a_reset_sweep, clock, reset, !req_ready)
   `VRCG_ASSERT_IMPL(a_hit_bits, clock, reset, rsp_valid && dynamic_hit, cell_bits[2] && in_grid)
   `VRCG_ASSERT_IMPL(a_bits_in_grid, clock, reset, rsp_valid && cell_bits != 3'd0, in_grid)
endmodule

bind voxel_ray_clearing_grid vrcg_checker u_vrcg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .cell_bits   (rsp_chan.cell_bits),
   .in_grid     (rsp_chan.in_grid),
   .dynamic_hit (rsp_chan.dynamic_hit)
);
`default_nettype wire

FILE: bench/tb_voxel_ray_clearing_grid.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_voxel_ray_clearing_grid;
   localparam int NX = vrcg_pkg::GRID_XY_DEF;
   localparam int NZ = vrcg_pkg::GRID_Z_DEF;
   localparam int NCELLS = NX * NX * NZ;
   // The reset clearing pass, a few full clears and the full-grid scan boxes are the
   // longest items. The limit leaves a wide margin over the slowest run.
   localparam int CYCLE_LIMIT = 12000000;

   // opcodes with no operation
   localparam logic [vrcg_pkg::OPC_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [vrcg_pkg::OPC_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [vrcg_pkg::OPC_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [vrcg_pkg::OPC_W-1:0]        opcode;
      logic signed [vrcg_pkg::VXY_W-1:0] vx;
      logic signed [vrcg_pkg::VXY_W-1:0] vy;
      logic signed [vrcg_pkg::VZ_W-1:0]  vz;
      logic [vrcg_pkg::HXY_W-1:0]        hxy;
      logic [vrcg_pkg::HZ_W-1:0]         hz;
   } grid_op_type;

   typedef struct packed {
      logic [vrcg_pkg::CELL_W-1:0] cell_bits;
      logic                        in_grid;
      logic                        dynamic_hit;
   } cell_resp_type;

   logic clock;
   logic reset;

   vrcg_req_if req_chan ();
   vrcg_rsp_if rsp_chan ();
   vrcg_csr_if csr_chan ();

   voxel_ray_clearing_grid dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // ---------------------------------------------------------------------------
   // Shadow grid and centre registers
   // ---------------------------------------------------------------------------
   logic [vrcg_pkg::CELL_W-1:0] shadow_cells [NCELLS];
   int ctr_x = vrcg_pkg::CENTER_X_RST;
   int ctr_y = vrcg_pkg::CENTER_Y_RST;
   int ctr_z = vrcg_pkg::CENTER_Z_RST;

   grid_op_type   pending_ops [$];   // items waiting for the driver
   cell_resp_type expected_resp [$]; // predicted results, oldest first
   int            error_count = 0;
   int            cycle_count = 0;
   logic          req_taken = 1'b0;  // request transfer at the last rising edge

   function automatic void queue_op(grid_op_type op);
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   function automatic bit in_bounds(int x, int y, int z);
      return x >= 0 && x < NX && y >= 0 && y < NX && z >= 0 && z < NZ;
   endfunction

   function automatic int cell_addr(int x, int y, int z);
      return (z * NX + y) * NX + x;
   endfunction

   function automatic int clamp_low(int v);
      return (v < 0) ? 0 : v;
   endfunction

   function automatic int clamp_high(int v, int n);
      return (v > n - 1) ? n - 1 : v;
   endfunction

   function automatic void trace_ray(int tx, int ty, int tz);
      int dx, dy, dz, ax, ay, az, sx, sy, sz, axis, major, x, y, z, a;
      dx = tx - ctr_x; dy = ty - ctr_y; dz = tz - ctr_z;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
      sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
      sz = dz > 0 ? 1 : (dz < 0 ? -1 : 0);
      if (ax == 0 && ay == 0 && az == 0) return;
      // dominant axis, ties resolved x then y then z
      if (ax >= ay && ax >= az) begin
         axis = 0; major = ax;
      end else if (ay >= az) begin
         axis = 1; major = ay;
      end else begin
         axis = 2; major = az;
      end
      for (int i = 1; i < major; i++) begin
         x = ctr_x + sx * (axis == 0 ? i : (i * ax) / major);
         y = ctr_y + sy * (axis == 1 ? i : (i * ay) / major);
         z = ctr_z + sz * (axis == 2 ? i : (i * az) / major);
         if (!in_bounds(x, y, z)) break;
         a = cell_addr(x, y, z);
         if ((shadow_cells[a] & vrcg_pkg::CELL_SCAN) != 0) break;
         shadow_cells[a] = shadow_cells[a] | vrcg_pkg::CELL_RAY;
      end
   endfunction

   // Applies one operation to the shadow grid and returns the expected result.
   function automatic cell_resp_type apply_grid_op(grid_op_type op);
      cell_resp_type r;
      int x, y, z, hxy, hz;
      x = $signed(op.vx); y = $signed(op.vy); z = $signed(op.vz);
      hxy = op.hxy; hz = op.hz;
      r = '0;
      r.in_grid = in_bounds(x, y, z);
      case (op.opcode)
         vrcg_pkg::OP_CLEAR: begin
            foreach (shadow_cells[i]) shadow_cells[i] = '0;
         end
         vrcg_pkg::OP_SCAN: begin
            for (int zz = clamp_low(z - hz); zz <= clamp_high(z + hz, NZ); zz++)
               for (int yy = clamp_low(y - hxy); yy <= clamp_high(y + hxy, NX); yy++)
                  for (int xx = clamp_low(x - hxy); xx <= clamp_high(x + hxy, NX); xx++)
                     shadow_cells[cell_addr(xx, yy, zz)] |= vrcg_pkg::CELL_SCAN;
         end
         vrcg_pkg::OP_OBS: begin
            if (r.in_grid) shadow_cells[cell_addr(x, y, z)] |= vrcg_pkg::CELL_OBS;
         end
         vrcg_pkg::OP_RAY: trace_ray(x, y, z);
         vrcg_pkg::OP_QUERY: begin
            if (r.in_grid) begin
               r.cell_bits   = shadow_cells[cell_addr(x, y, z)];
               r.dynamic_hit = (r.cell_bits & vrcg_pkg::CELL_RAY) != 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic grid_op_type mk_op(logic [vrcg_pkg::OPC_W-1:0] opc, int x, int y,
                                         int z, int hxy = 0, int hz = 0);
      grid_op_type op;
      op.opcode = opc;
      op.vx  = x[vrcg_pkg::VXY_W-1:0];
      op.vy  = y[vrcg_pkg::VXY_W-1:0];
      op.vz  = z[vrcg_pkg::VZ_W-1:0];
      op.hxy = hxy[vrcg_pkg::HXY_W-1:0];
      op.hz  = hz[vrcg_pkg::HZ_W-1:0];
      return op;
   endfunction

   // Target coordinate: mostly in grid, some near the centre, some anywhere
   function automatic int pick_coord(int n, int ctr, int w);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return $urandom_range(0, n - 1);
      if (sel < 85) return ctr + $urandom_range(0, 8) - 4;
      if (sel < 95) return $urandom_range(0, 3 * n - 1) - n;
      return $signed(($urandom() & ((1 << w) - 1)) << (32 - w)) >>> (32 - w);
   endfunction

   function automatic grid_op_type rand_op();
      logic [vrcg_pkg::OPC_W-1:0] opc;
      int sel, spare, hxy, hz;
      sel = $urandom_range(0, 999);
      hxy = $urandom_range(0, 2);
      hz  = $urandom_range(0, 2);
      if (sel < 2) opc = vrcg_pkg::OP_CLEAR;          // a clear costs a full sweep
      else if (sel < 150) begin
         opc = vrcg_pkg::OP_SCAN;
         if ($urandom_range(0, 99) == 0) begin
            hxy = $urandom_range(0, 63); hz = $urandom_range(0, 15);
         end
      end
      else if (sel < 300) opc = vrcg_pkg::OP_OBS;
      else if (sel < 580) opc = vrcg_pkg::OP_RAY;
      else if (sel < 970) opc = vrcg_pkg::OP_QUERY;
      else begin
         spare = $urandom_range(0, 2);
         opc = (spare == 0) ? OP_SPARE_5 : ((spare == 1) ? OP_SPARE_6 : OP_SPARE_7);
         hxy = $urandom_range(0, 63); hz = $urandom_range(0, 15);
      end
      return mk_op(opc, pick_coord(NX, ctr_x, vrcg_pkg::VXY_W),
                   pick_coord(NX, ctr_y, vrcg_pkg::VXY_W),
                   pick_coord(NZ, ctr_z, vrcg_pkg::VZ_W), hxy, hz);
   endfunction

   task automatic wait_idle();
      while (pending_ops.size() != 0 || expected_resp.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [vrcg_pkg::CSR_IDX_W-1:0] idx,
                            logic [vrcg_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_chan.addr  <= idx;
      csr_chan.data  <= val;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         vrcg_pkg::CSR_CENTER_X: ctr_x = int'(val);
         vrcg_pkg::CSR_CENTER_Y: ctr_y = int'(val);
         vrcg_pkg::CSR_CENTER_Z: ctr_z = int'(val[vrcg_pkg::CZ_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_center(int x, int y, int z);
      wait_idle();
      csr_write(vrcg_pkg::CSR_CENTER_X, x[vrcg_pkg::CSR_DATA_W-1:0]);
      csr_write(vrcg_pkg::CSR_CENTER_Y, y[vrcg_pkg::CSR_DATA_W-1:0]);
      csr_write(vrcg_pkg::CSR_CENTER_Z, z[vrcg_pkg::CSR_DATA_W-1:0]);
   endtask

   // ---------------------------------------------------------------------------
   // Clock, reset, known input values
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = '0; req_chan.voxel_x = '0; req_chan.voxel_y = '0;
      req_chan.voxel_z = '0; req_chan.half_xy = '0; req_chan.half_z = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0; csr_chan.addr = '0; csr_chan.data = '0;
   end

   // ---------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------------
   int burst_left = 4;
   int gap_left   = 0;

   always @(negedge clock) begin
      grid_op_type op;
      if (!reset && (req_taken || !req_chan.valid)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            op = pending_ops.pop_front();
            req_chan.opcode  <= op.opcode;
            req_chan.voxel_x <= op.vx;
            req_chan.voxel_y <= op.vy;
            req_chan.voxel_z <= op.vz;
            req_chan.half_xy <= op.hxy;
            req_chan.half_z  <= op.hz;
            req_chan.valid   <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: mode switches now and then between open, random and long stalls
   int rdy_mode = 0;
   int rdy_hold = 0;

   always @(negedge clock) begin
      if (rdy_hold == 0) begin
         rdy_mode = $urandom_range(0, 2);
         rdy_hold = $urandom_range(20, 400);
      end
      rdy_hold = rdy_hold - 1;
      case (rdy_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         default: rsp_chan.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on request transfer, check on response transfer
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      grid_op_type op;
      cell_resp_type got, want;
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
      req_taken <= req_chan.valid && req_chan.ready && !reset;
      if (!reset && req_chan.valid && req_chan.ready) begin
         op.opcode = req_chan.opcode;
         op.vx = req_chan.voxel_x; op.vy = req_chan.voxel_y; op.vz = req_chan.voxel_z;
         op.hxy = req_chan.half_xy; op.hz = req_chan.half_z;
         expected_resp.insert(expected_resp.size(), apply_grid_op(op));
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.cell_bits   = rsp_chan.cell_bits;
         got.in_grid     = rsp_chan.in_grid;
         got.dynamic_hit = rsp_chan.dynamic_hit;
         if (expected_resp.size() == 0) begin
            $display("%0t unexpected transfer: expected none, actual bits=%0d in=%0d hit=%0d",
                     $time, got.cell_bits, got.in_grid, got.dynamic_hit);
            error_count++;
         end else begin
            want = expected_resp.pop_front();
            if (got.cell_bits !== want.cell_bits) begin
               $display("%0t cell_bits mismatch: expected %0d actual %0d",
                        $time, want.cell_bits, got.cell_bits);
               error_count++;
            end
            if (got.in_grid !== want.in_grid) begin
               $display("%0t in_grid mismatch: expected %0d actual %0d",
                        $time, want.in_grid, got.in_grid);
               error_count++;
            end
            if (got.dynamic_hit !== want.dynamic_hit) begin
               $display("%0t dynamic_hit mismatch: expected %0d actual %0d",
                        $time, want.dynamic_hit, got.dynamic_hit);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults centre 32/32/8
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 32, 32, 8));
      queue_op(mk_op(vrcg_pkg::OP_OBS, 40, 32, 8));
      queue_op(mk_op(vrcg_pkg::OP_OBS, -64, 127, 31));          // outside, ignored
      queue_op(mk_op(vrcg_pkg::OP_RAY, 32, 32, 8));             // target on centre
      queue_op(mk_op(vrcg_pkg::OP_RAY, 40, 32, 8));             // x dominant
      queue_op(mk_op(vrcg_pkg::OP_RAY, 35, 38, 10));            // y dominant
      queue_op(mk_op(vrcg_pkg::OP_RAY, 30, 31, 2));             // z dominant
      queue_op(mk_op(vrcg_pkg::OP_RAY, 36, 36, 12));            // three-way tie
      queue_op(mk_op(vrcg_pkg::OP_RAY, 127, -64, -16));         // leaves the grid
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 36, 32, 8));
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 40, 32, 8));           // ray end not marked
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 32, 32, 8));           // centre not marked
      queue_op(mk_op(vrcg_pkg::OP_SCAN, 36, 32, 8, 0, 0));
      queue_op(mk_op(vrcg_pkg::OP_RAY, 50, 32, 8));             // blocked by scan cell
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 37, 32, 8));
      queue_op(mk_op(vrcg_pkg::OP_SCAN, 63, 63, 15, 2, 1));     // clipped corner
      queue_op(mk_op(vrcg_pkg::OP_SCAN, -64, -64, -16, 63, 15));// box outside the grid
      queue_op(mk_op(vrcg_pkg::OP_SCAN, 100, 10, 4, 3, 1));     // box past the far edge
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 63, 10, 4));
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 0, 0, 0));
      queue_op(mk_op(vrcg_pkg::OP_QUERY, -64, 127, -16));       // outside
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 63, 63, 15));
      queue_op(mk_op(OP_SPARE_5, 1, 2, 3, 63, 15));
      queue_op(mk_op(OP_SPARE_7, -1, -1, -1, 63, 15));
      queue_op(mk_op(vrcg_pkg::OP_CLEAR, 127, 127, 31));        // out-of-grid target
      queue_op(mk_op(vrcg_pkg::OP_SCAN, 32, 32, 8, 63, 15));    // whole grid
      queue_op(mk_op(vrcg_pkg::OP_CLEAR, 1, 1, 1));
      queue_op(mk_op(vrcg_pkg::OP_QUERY, 63, 0, 15));

      // random phases over several centre settings; the sender drains between them
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: set_center(0, 0, 0);
            2: set_center(63, 63, 63);   // upper data bits of centre_z are dropped
            3: set_center($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            4: set_center(vrcg_pkg::CENTER_X_RST, vrcg_pkg::CENTER_Y_RST,
                          vrcg_pkg::CENTER_Z_RST);
            default: ;
         endcase
         for (int n = 0; n < 400; n++) queue_op(rand_op());
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
